// ===== design/int_stack_alu_defines.svh =====
// Assertion macros shared by the int_stack_alu RTL.
// Relies on i_clk and i_rst_n in the including module.
`ifndef INT_STACK_ALU_DEFINES_SVH
`define INT_STACK_ALU_DEFINES_SVH

// consequent must hold in the cycle of the antecedent
`define ISA_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// consequent must hold in the cycle after the antecedent
`define ISA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/isa_pkg.sv =====
// Shared types, widths and opcodes for int_stack_alu.
// No dependencies.
package isa_pkg;
    localparam int DATA_WIDTH = 32;
    localparam int OP_WIDTH   = 5;
    localparam int N_STAGES   = DATA_WIDTH + 2;

    localparam logic [OP_WIDTH-1:0] OP_LT   = 5'd0;
    localparam logic [OP_WIDTH-1:0] OP_GT   = 5'd1;
    localparam logic [OP_WIDTH-1:0] OP_EQ   = 5'd2;
    localparam logic [OP_WIDTH-1:0] OP_LE   = 5'd3;
    localparam logic [OP_WIDTH-1:0] OP_GE   = 5'd4;
    localparam logic [OP_WIDTH-1:0] OP_NE   = 5'd5;
    localparam logic [OP_WIDTH-1:0] OP_SUB  = 5'd6;
    localparam logic [OP_WIDTH-1:0] OP_ADD  = 5'd7;
    localparam logic [OP_WIDTH-1:0] OP_MUL  = 5'd8;
    localparam logic [OP_WIDTH-1:0] OP_DIV  = 5'd9;
    localparam logic [OP_WIDTH-1:0] OP_MOD  = 5'd10;
    localparam logic [OP_WIDTH-1:0] OP_AND  = 5'd11;
    localparam logic [OP_WIDTH-1:0] OP_OR   = 5'd12;
    localparam logic [OP_WIDTH-1:0] OP_XOR  = 5'd13;
    localparam logic [OP_WIDTH-1:0] OP_NAND = 5'd14;
    localparam logic [OP_WIDTH-1:0] OP_NOR  = 5'd15;
    localparam logic [OP_WIDTH-1:0] OP_XNOR = 5'd16;
    localparam logic [OP_WIDTH-1:0] OP_NEG  = 5'd17;
    localparam logic [OP_WIDTH-1:0] OP_INV  = 5'd18;
    localparam logic [OP_WIDTH-1:0] OP_LNOT = 5'd19;
    localparam logic [OP_WIDTH-1:0] OP_RAND = 5'd20;
    localparam logic [OP_WIDTH-1:0] OP_ROR  = 5'd21;
    localparam logic [OP_WIDTH-1:0] OP_RXOR = 5'd22;
    localparam logic [OP_WIDTH-1:0] OP_RNAND = 5'd23;
    localparam logic [OP_WIDTH-1:0] OP_RNOR = 5'd24;
    localparam logic [OP_WIDTH-1:0] OP_RXNOR = 5'd25;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef struct packed {
        logic dv;     // divide result wanted
        logic md;     // remainder result wanted
        logic qn;     // negate quotient
        logic rn;     // negate remainder
        logic dz;     // zero divisor
        logic is_bit; // reduction result
    } t_side;
endpackage

// ===== design/isa_divstep.sv =====
// One restoring division step (one quotient bit) for int_stack_alu.
// Depends on isa_pkg.
module isa_divstep (
    input  isa_pkg::t_word i_rem,
    input  isa_pkg::t_word i_quo,
    input  isa_pkg::t_word i_dvs,
    output isa_pkg::t_word o_rem,
    output isa_pkg::t_word o_quo
);
    logic [isa_pkg::DATA_WIDTH:0] sh;
    logic [isa_pkg::DATA_WIDTH:0] diff;
    logic                         ge;

    assign sh    = {i_rem, i_quo[isa_pkg::DATA_WIDTH-1]};
    assign diff  = sh - {1'b0, i_dvs};
    assign ge    = !diff[isa_pkg::DATA_WIDTH];
    assign o_rem = ge ? diff[isa_pkg::DATA_WIDTH-1:0] : sh[isa_pkg::DATA_WIDTH-1:0];
    assign o_quo = {i_quo[isa_pkg::DATA_WIDTH-2:0], ge};
endmodule

// ===== design/int_stack_alu.sv =====
// Top level of int_stack_alu: pipelined 32-bit ALU for a stack machine.
// Depends on isa_pkg, isa_divstep and int_stack_alu_defines.svh.
//
// Usage:
//   Requests enter on the s-side stream: tuser carries the opcode, tdata the
//   popped stack operand (low 32 bits) and the accumulator (high 32 bits).
//   Results leave on the m-side stream: tdata is the new accumulator, tuser
//   bit 0 flags a one-bit reduction result, bit 1 a zero divisor.
//   Every opcode passes through all stages (one operand stage, one stage per
//   quotient bit of the divider, one output stage), so results stay in order.
//   Throughput is one request per cycle unless the receiver stalls; the
//   divider pipeline has 32 stages.
//   Each stage advances when the stage after it is empty or moving, so a
//   stalled receiver fills the pipeline bubble by bubble; o_s_tready drops
//   only when all 34 stages hold requests. Nothing is dropped or repeated.
//   Synchronous active-low reset empties all stages; payload is not cleared.
//   Opcodes 26 to 31 return the accumulator unchanged.
`include "int_stack_alu_defines.svh"
module int_stack_alu (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [2*isa_pkg::DATA_WIDTH-1:0]    i_s_tdata,  // stack_value[31:0], acc_value[63:32]
    input  logic [isa_pkg::OP_WIDTH-1:0]        i_s_tuser,  // op[4:0]
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [isa_pkg::DATA_WIDTH-1:0]      o_m_tdata,  // result[31:0]
    output logic [1:0]                          o_m_tuser   // result_is_bit[0], divide_by_zero[1]
);
    localparam int W  = isa_pkg::DATA_WIDTH;
    localparam int NS = isa_pkg::N_STAGES;

    logic                   r_vld  [NS];
    isa_pkg::t_side         r_side [NS-1];
    isa_pkg::t_word         r_nd   [NS-1];
    isa_pkg::t_word         r_rem  [NS-1];
    isa_pkg::t_word         r_quo  [NS-1];
    isa_pkg::t_word         r_dvs  [NS-1];
    isa_pkg::t_word         r_out;
    isa_pkg::t_side         r_oside;
    logic [NS-1:0]          en;

    // ---------------- operand stage
    logic [isa_pkg::OP_WIDTH-1:0] op;
    isa_pkg::t_word a, b, prod, n_nd, ma, mb;
    isa_pkg::t_side n_side;
    logic lt, gt, eq, ball, bzero, par;

    assign op    = i_s_tuser;
    assign a     = i_s_tdata[W-1:0];
    assign b     = i_s_tdata[2*W-1:W];
    assign prod  = a * b;
    assign lt    = $signed(a) < $signed(b);
    assign gt    = $signed(b) < $signed(a);
    assign eq    = a == b;
    assign ball  = &b;
    assign bzero = b == '0;
    assign par   = ^b;
    assign ma    = a[W-1] ? (~a + 1'b1) : a;
    assign mb    = b[W-1] ? (~b + 1'b1) : b;

    always_comb begin
        n_nd   = b;
        n_side = '0;
        case (op)
            isa_pkg::OP_LT:    n_nd = W'(lt);
            isa_pkg::OP_GT:    n_nd = W'(gt);
            isa_pkg::OP_EQ:    n_nd = W'(eq);
            isa_pkg::OP_LE:    n_nd = W'(!gt);
            isa_pkg::OP_GE:    n_nd = W'(!lt);
            isa_pkg::OP_NE:    n_nd = W'(!eq);
            isa_pkg::OP_SUB:   n_nd = a - b;
            isa_pkg::OP_ADD:   n_nd = a + b;
            isa_pkg::OP_MUL:   n_nd = prod;
            isa_pkg::OP_DIV, isa_pkg::OP_MOD: begin
                n_side.dz = bzero;
                n_side.dv = !bzero && (op == isa_pkg::OP_DIV);
                n_side.md = !bzero && (op == isa_pkg::OP_MOD);
                n_side.qn = a[W-1] ^ b[W-1];
                n_side.rn = a[W-1];
            end
            isa_pkg::OP_AND:   n_nd = a & b;
            isa_pkg::OP_OR:    n_nd = a | b;
            isa_pkg::OP_XOR:   n_nd = a ^ b;
            isa_pkg::OP_NAND:  n_nd = ~(a & b);
            isa_pkg::OP_NOR:   n_nd = ~(a | b);
            isa_pkg::OP_XNOR:  n_nd = ~(a ^ b);
            isa_pkg::OP_NEG:   n_nd = ~b + 1'b1;
            isa_pkg::OP_INV:   n_nd = ~b;
            isa_pkg::OP_LNOT:  n_nd = W'(bzero);
            isa_pkg::OP_RAND:  begin n_nd = W'(ball);   n_side.is_bit = 1'b1; end
            isa_pkg::OP_ROR:   begin n_nd = W'(!bzero); n_side.is_bit = 1'b1; end
            isa_pkg::OP_RXOR:  begin n_nd = W'(par);    n_side.is_bit = 1'b1; end
            isa_pkg::OP_RNAND: begin n_nd = W'(!ball);  n_side.is_bit = 1'b1; end
            isa_pkg::OP_RNOR:  begin n_nd = W'(bzero);  n_side.is_bit = 1'b1; end
            isa_pkg::OP_RXNOR: begin n_nd = W'(!par);   n_side.is_bit = 1'b1; end
            default:           n_nd = b;
        endcase
    end

    // ---------------- stage advance chain
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en[0]) begin
            r_vld[0] <= i_s_tvalid;
        end
        if (en[0] && i_s_tvalid) begin
            r_side[0] <= n_side;
            r_nd[0]   <= n_nd;
            r_rem[0]  <= '0;
            r_quo[0]  <= ma;
            r_dvs[0]  <= mb;
        end
    end

    // ---------------- divider stages, one quotient bit each
    for (genvar s = 1; s <= W; s++) begin : g_div
        isa_pkg::t_word n_rem, n_quo;

        isa_divstep u_step (
            .i_rem (r_rem[s-1]),
            .i_quo (r_quo[s-1]),
            .i_dvs (r_dvs[s-1]),
            .o_rem (n_rem),
            .o_quo (n_quo)
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (en[s]) begin
                r_vld[s] <= r_vld[s-1];
            end
            if (en[s] && r_vld[s-1]) begin
                r_side[s] <= r_side[s-1];
                r_nd[s]   <= r_nd[s-1];
                r_rem[s]  <= n_rem;
                r_quo[s]  <= n_quo;
                r_dvs[s]  <= r_dvs[s-1];
            end
        end
    end

    // ---------------- output stage: sign fix and select
    isa_pkg::t_word n_out;
    isa_pkg::t_side fs;

    assign fs = r_side[W];

    always_comb begin
        n_out = r_nd[W];
        if (fs.dv) begin
            n_out = fs.qn ? (~r_quo[W] + 1'b1) : r_quo[W];
        end else if (fs.md) begin
            n_out = fs.rn ? (~r_rem[W] + 1'b1) : r_rem[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[NS-1] <= 1'b0;
        end else if (en[NS-1]) begin
            r_vld[NS-1] <= r_vld[W];
        end
        if (en[NS-1] && r_vld[W]) begin
            r_out   <= n_out;
            r_oside <= fs;
        end
    end

    assign o_m_tvalid = r_vld[NS-1];
    assign o_m_tdata  = r_out;
    assign o_m_tuser  = {r_oside.dz, r_oside.is_bit};

    `ISA_ASSERT_IMPLY(a_dz_zero, o_m_tvalid && o_m_tuser[1], o_m_tdata == '0)
    `ISA_ASSERT_IMPLY(a_bit_narrow, o_m_tvalid && o_m_tuser[0], o_m_tdata[W-1:1] == '0)
    `ISA_ASSERT_IMPLY(a_flags_excl, o_m_tvalid, !(o_m_tuser[0] && o_m_tuser[1]))
    `ISA_ASSERT_NEXT(a_take_lands, i_s_tvalid && o_s_tready, r_vld[0])
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for int_stack_alu: directed table, then random requests.
// Depends on isa_pkg and the int_stack_alu RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [isa_pkg::OP_WIDTH-1:0] op;
        isa_pkg::t_word               stk;
        isa_pkg::t_word               acc;
    } t_req;

    typedef struct packed {
        isa_pkg::t_word res;
        logic           is_bit;
        logic           dz;
    } t_res;

    typedef struct {
        t_req req;
        logic known;
        t_res res;
    } t_row;

    localparam isa_pkg::t_word MIN_W = 32'h8000_0000;
    localparam isa_pkg::t_word MAX_W = 32'h7fff_ffff;
    localparam isa_pkg::t_word ONES  = 32'hffff_ffff;
    localparam int             N_RANDOM = 700;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [63:0]         i_s_tdata;
    logic [4:0]          i_s_tuser;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [31:0]         o_m_tdata;
    logic [1:0]          o_m_tuser;

    t_res   alu_expect_q[$];
    t_req   req_q[$];
    t_row   directed[$];
    int     n_err;
    logic   stim_done;
    logic   hold_rx;
    logic   quiet_rx;

    int_stack_alu DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic lt_s(isa_pkg::t_word a, isa_pkg::t_word b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic t_res alu_predict(t_req q);
        t_res           r;
        isa_pkg::t_word a;
        isa_pkg::t_word b;
        isa_pkg::t_word ma;
        isa_pkg::t_word mb;
        a = q.stk;
        b = q.acc;
        r = '{res: b, is_bit: 1'b0, dz: 1'b0};
        case (q.op)
            isa_pkg::OP_LT:    r.res = isa_pkg::t_word'(lt_s(a, b));
            isa_pkg::OP_GT:    r.res = isa_pkg::t_word'(lt_s(b, a));
            isa_pkg::OP_EQ:    r.res = isa_pkg::t_word'(a == b);
            isa_pkg::OP_LE:    r.res = isa_pkg::t_word'(!lt_s(b, a));
            isa_pkg::OP_GE:    r.res = isa_pkg::t_word'(!lt_s(a, b));
            isa_pkg::OP_NE:    r.res = isa_pkg::t_word'(a != b);
            isa_pkg::OP_SUB:   r.res = a - b;
            isa_pkg::OP_ADD:   r.res = a + b;
            isa_pkg::OP_MUL:   r.res = a * b;
            isa_pkg::OP_DIV, isa_pkg::OP_MOD: begin
                if (b == '0) begin
                    r.dz = 1'b1;
                end else begin
                    ma = a[31] ? -a : a;
                    mb = b[31] ? -b : b;
                    if (q.op == isa_pkg::OP_DIV) begin
                        r.res = ma / mb;
                        if (a[31] ^ b[31]) r.res = -r.res;
                    end else begin
                        r.res = ma % mb;
                        if (a[31]) r.res = -r.res;
                    end
                end
            end
            isa_pkg::OP_AND:   r.res = a & b;
            isa_pkg::OP_OR:    r.res = a | b;
            isa_pkg::OP_XOR:   r.res = a ^ b;
            isa_pkg::OP_NAND:  r.res = ~(a & b);
            isa_pkg::OP_NOR:   r.res = ~(a | b);
            isa_pkg::OP_XNOR:  r.res = ~(a ^ b);
            isa_pkg::OP_NEG:   r.res = -b;
            isa_pkg::OP_INV:   r.res = ~b;
            isa_pkg::OP_LNOT:  r.res = isa_pkg::t_word'(b == '0);
            isa_pkg::OP_RAND:  begin r.res = isa_pkg::t_word'(&b);  r.is_bit = 1'b1; end
            isa_pkg::OP_ROR:   begin r.res = isa_pkg::t_word'(|b);  r.is_bit = 1'b1; end
            isa_pkg::OP_RXOR:  begin r.res = isa_pkg::t_word'(^b);  r.is_bit = 1'b1; end
            isa_pkg::OP_RNAND: begin r.res = isa_pkg::t_word'(~&b); r.is_bit = 1'b1; end
            isa_pkg::OP_RNOR:  begin r.res = isa_pkg::t_word'(~|b); r.is_bit = 1'b1; end
            isa_pkg::OP_RXNOR: begin r.res = isa_pkg::t_word'(~^b); r.is_bit = 1'b1; end
            default:  ;
        endcase
        return r;
    endfunction

    function automatic isa_pkg::t_word rand_word();
        case ($urandom_range(0, 9))
            0:       return MIN_W;
            1:       return MAX_W;
            2:       return ONES;
            3:       return '0;
            4:       return isa_pkg::t_word'($urandom_range(0, 8));
            5:       return -isa_pkg::t_word'($urandom_range(1, 8));
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(logic [isa_pkg::OP_WIDTH-1:0] op, isa_pkg::t_word s,
                           isa_pkg::t_word a,
                           logic known = 1'b0, isa_pkg::t_word r = '0,
                           logic bt = 1'b0, logic z = 1'b0);
        t_row w;
        w.req = '{op: op, stk: s, acc: a};
        w.known = known;
        w.res = '{res: r, is_bit: bt, dz: z};
        directed.push_back(w);
    endtask

    // sender
    initial begin
        t_req q;
        int   quiet;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        stim_done = 1'b0;
        n_err = 0;
        add_row(isa_pkg::OP_DIV, 32'd7, '0, 1'b1, '0, 1'b0, 1'b1);
        add_row(isa_pkg::OP_MOD, MIN_W, '0, 1'b1, '0, 1'b0, 1'b1);
        add_row(isa_pkg::OP_DIV, MIN_W, ONES, 1'b1, MIN_W);
        add_row(isa_pkg::OP_MOD, MIN_W, ONES, 1'b1, '0);
        add_row(isa_pkg::OP_NEG, '0, MIN_W, 1'b1, MIN_W);
        add_row(isa_pkg::OP_RAND, '0, ONES, 1'b1, 32'd1, 1'b1);
        add_row(isa_pkg::OP_RNAND, '0, ONES, 1'b1, '0, 1'b1);
        add_row(isa_pkg::OP_RAND, '0, MAX_W, 1'b1, '0, 1'b1);
        add_row(isa_pkg::OP_ADD, MAX_W, 32'd1, 1'b1, MIN_W);
        add_row(isa_pkg::OP_SUB, MIN_W, 32'd1, 1'b1, MAX_W);
        add_row(5'd26, ONES, 32'd5, 1'b1, 32'd5);
        add_row(5'd31, '0, MIN_W, 1'b1, MIN_W);
        add_row(isa_pkg::OP_DIV, -32'sd7, 32'd2);
        add_row(isa_pkg::OP_MOD, -32'sd7, 32'd2);
        add_row(isa_pkg::OP_MOD, 32'd7, -32'sd2);
        add_row(isa_pkg::OP_MUL, MIN_W, MIN_W);
        add_row(isa_pkg::OP_LT, MIN_W, MAX_W);
        add_row(isa_pkg::OP_GE, MAX_W, MIN_W);
        for (int o = 0; o <= isa_pkg::OP_RXNOR; o++) begin
            add_row(o[4:0], rand_word(), rand_word());
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) req_q.push_back(directed[k].req);
        for (int k = 0; k < N_RANDOM; k++) begin
            q.op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(26, 31))
                                                : 5'($urandom_range(0, 25));
            q.stk = rand_word();
            q.acc = rand_word();
            req_q.push_back(q);
        end
        foreach (req_q[k]) begin
            quiet = (k >= 200 && k < 320);
            if (!quiet) begin
                while ($urandom_range(0, 99) < 14) begin
                    i_s_tvalid <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_s_tvalid <= 1'b1;
            i_s_tuser <= req_q[k].op;
            i_s_tdata <= {req_q[k].acc, req_q[k].stk};
            q = req_q[k];
            alu_expect_q.push_back(alu_predict(q));
            if (k < directed.size() && directed[k].known &&
                alu_predict(q) != directed[k].res) begin
                $display("%0t: table row %0d exp %h got model %h", $time, k,
                         directed[k].res, alu_predict(q));
                n_err++;
            end
            @(posedge i_clk iff o_s_tready);
        end
        i_s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver hold-off, its own counter
    initial begin
        hold_rx = 1'b0;
        wait (i_rst_n);
        repeat (150) @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (120) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    initial begin
        quiet_rx = 1'b0;
        wait (i_rst_n);
        repeat (500) @(posedge i_clk);
        quiet_rx <= 1'b1;
        repeat (250) @(posedge i_clk);
        quiet_rx <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= !hold_rx && (quiet_rx || $urandom_range(0, 99) >= 14);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (alu_expect_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_m_tdata);
                n_err++;
            end else begin
                e = alu_expect_q.pop_front();
                if (o_m_tdata !== e.res) begin
                    $display("%0t: result exp %h got %h", $time, e.res, o_m_tdata);
                    n_err++;
                end
                if (o_m_tuser[0] !== e.is_bit) begin
                    $display("%0t: is_bit exp %b got %b", $time, e.is_bit, o_m_tuser[0]);
                    n_err++;
                end
                if (o_m_tuser[1] !== e.dz) begin
                    $display("%0t: div_zero exp %b got %b", $time, e.dz, o_m_tuser[1]);
                    n_err++;
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        wait (alu_expect_q.size() == 0);
        repeat (2 * isa_pkg::N_STAGES + 10) @(posedge i_clk);
        if (n_err == 0 && alu_expect_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
